// ===== hdl/ternary_match_priority_table_macros.svh =====
// Assertion macros shared by the checker of the ternary match table.
`ifndef TERNARY_MATCH_PRIORITY_TABLE_MACROS_SVH
`define TERNARY_MATCH_PRIORITY_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TMPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define TMPT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/tmpt_pkg.sv =====
// Shared types and constants of the ternary match table.
package tmpt_pkg;

  localparam int unsigned RULE_COUNT_DEF = 16;
  localparam int unsigned WORD_BITS_DEF  = 64;

  localparam int unsigned FIELD_W   = 64;
  localparam int unsigned IDX_IN_W  = 8;
  localparam int unsigned HIT_IDX_W = 4;

  // Slave tdata layout, lowest bit first.
  localparam int unsigned RIDX_LSB  = 0;
  localparam int unsigned KEY_LSB   = RIDX_LSB + IDX_IN_W;
  localparam int unsigned MASK_LSB  = KEY_LSB + FIELD_W;
  localparam int unsigned WORD_LSB  = MASK_LSB + FIELD_W;
  localparam int unsigned S_DATA_W  = WORD_LSB + FIELD_W;

  localparam int unsigned RES_W     = 2 + HIT_IDX_W;
  localparam int unsigned M_DATA_W  = 8;
  localparam int unsigned M_PAD_W   = M_DATA_W - RES_W;

  localparam logic CMD_INSTALL = 1'b0;
  localparam logic CMD_LOOKUP  = 1'b1;

  typedef struct packed {
    logic [HIT_IDX_W-1:0] hit_index;
    logic                 hit;
    logic                 install_ok;
  } res_t;

endpackage

// ===== hdl/tmpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tmpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tmpt_match.sv =====
// Masked ternary compare of one stored rule against the search word.
module tmpt_match #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WORD_BITS-1:0] key_i,
  input  logic [WORD_BITS-1:0] mask_i,
  input  logic                 claimed_i,
  output logic                 match_o
);

  // Mismatch only counts where the rule cares.
  assign match_o = claimed_i && (((word_i ^ key_i) & mask_i) == '0);

endmodule

// ===== hdl/ternary_match_priority_table.sv =====
// Top level of the ternary match table: sequencer, rule store and claim flags.
//
//  Channel  Dir  Fields (tdata from bit 0 / tuser)
//  s_axis   in   tdata: rule_index[7:0] key_value[71:8] care_mask[135:72]
//                lookup_word[199:136]; tuser: cmd
//  m_axis   out  tdata: install_ok[0] hit[1] hit_index[5:2], zero pad [7:6]
//
//  Install: the result goes to res_q, then to the output register when free.
//  Lookup: one rule per cycle through the single RAM read port, the compare in
//  the cycle after the read; a hit ends the scan at the first matching rule, a
//  miss after the last rule. s_axis_tready rises as the result is loaded. A
//  result waiting in the output register does not block the next transfer; a
//  second finished result holds the block. Reset clears state and all flags.
module ternary_match_priority_table
  import tmpt_pkg::*;
#(
  parameter int unsigned RULE_COUNT = RULE_COUNT_DEF,
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // rule_index, key_value, care_mask, lookup_word (low to high)
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // cmd
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // install_ok, hit, hit_index, zero pad (low to high)
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam logic [IDX_W:0]   RULES_CNT = (IDX_W + 1)'(RULE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RULE_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [WORD_BITS-1:0] word_q;
  logic [IDX_W:0]       ptr_q, ptr_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  res_t                 res_q, res_d;
  logic                 out_vld_q, out_vld_d;
  res_t                 out_res_q;
  logic [RULE_COUNT-1:0] claimed_q;

  logic                 in_fire;
  logic                 in_cmd;
  logic [IDX_IN_W-1:0]  in_ridx;
  logic [WORD_BITS-1:0] in_key, in_mask, in_word;
  logic [IDX_W-1:0]     slot;
  logic                 slot_ok;
  logic                 install_ok;
  logic                 out_free;

  logic                 ram_we, ram_re;
  logic [2*WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic                 match;

  assign in_cmd  = s_axis_tuser;
  assign in_ridx = s_axis_tdata[RIDX_LSB +: IDX_IN_W];
  assign in_key  = s_axis_tdata[KEY_LSB  +: WORD_BITS];
  assign in_mask = s_axis_tdata[MASK_LSB +: WORD_BITS];
  assign in_word = s_axis_tdata[WORD_LSB +: WORD_BITS];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign slot       = in_ridx[IDX_W-1:0];
  assign slot_ok    = ({1'b0, in_ridx} < (IDX_IN_W + 1)'(RULE_COUNT));
  assign install_ok = slot_ok && !claimed_q[slot];

  assign out_free  = !out_vld_q || m_axis_tready;
  assign ram_wdata = {in_mask, in_key};

  tmpt_ram #(
    .WIDTH (2 * WORD_BITS),
    .DEPTH (RULE_COUNT)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  tmpt_match #(
    .WORD_BITS (WORD_BITS)
  ) u_match (
    .word_i    (word_q),
    .key_i     (ram_rdata[WORD_BITS-1:0]),
    .mask_i    (ram_rdata[2*WORD_BITS-1:WORD_BITS]),
    .claimed_i (claimed_q[cmp_idx_q]),
    .match_o   (match)
  );

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_d = '0;
          if (in_cmd == CMD_INSTALL) begin
            res_d.install_ok = install_ok;
            ram_we           = install_ok;
            state_d          = ST_DONE;
          end else begin
            ptr_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Compare runs in the cycle after the RAM read.
        if (cmp_vld_q && match) begin
          res_d.hit       = 1'b1;
          res_d.hit_index = HIT_IDX_W'(cmp_idx_q);
          state_d         = ST_DONE;
        end else if (cmp_vld_q && (cmp_idx_q == LAST_IDX)) begin
          state_d = ST_DONE;
        end else if (ptr_q < RULES_CNT) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if ((state_q == ST_DONE) && out_free) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      claimed_q <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
      if (in_fire && (in_cmd == CMD_INSTALL) && install_ok) begin
        claimed_q[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    if (in_fire) begin
      word_q <= in_word;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_res_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_res_q};

endmodule

// ===== hdl/tmpt_checker.sv =====
// Port-level checker of the ternary match table, bound to the top level.
`include "ternary_match_priority_table_macros.svh"

module tmpt_checker
  import tmpt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata
);

  logic in_xfer;
  res_t out_res;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign out_res = res_t'(m_axis_tdata[RES_W-1:0]);

  `TMPT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `TMPT_ASSERT(a_busy_after_in, in_xfer |=> !s_axis_tready, "second item taken while busy")
  `TMPT_NEVER(a_ok_and_hit, m_axis_tvalid && out_res.install_ok && out_res.hit, "install_ok and hit both set")
  `TMPT_NEVER(a_idx_on_miss, m_axis_tvalid && !out_res.hit && (out_res.hit_index != '0), "nonzero index without hit")

endmodule

bind ternary_match_priority_table tmpt_checker u_tmpt_checker (.*);

// ===== test/tb_top.sv =====
// Testbench for the ternary match table: installs and lookups against a rule predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmpt_pkg::*;

  localparam int unsigned RULE_COUNT = RULE_COUNT_DEF;
  localparam int unsigned RAND_OPS  = 750;
  localparam int unsigned DRAIN_AT  = 480;  // sender waits for all results after this many
  localparam int unsigned HOLD_AT   = 220;  // receiver holds off after this many results
  localparam int unsigned HOLD_LEN  = 300;

  typedef struct {
    logic        cmd;
    logic [7:0]  idx;
    logic [63:0] key;
    logic [63:0] mask;
    logic [63:0] word;
  } op_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_ready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  ternary_match_priority_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // rule table as the predictor sees it
  logic [63:0] rule_key  [RULE_COUNT];
  logic [63:0] rule_mask [RULE_COUNT];
  logic        rule_used [RULE_COUNT];

  // rules as planned by the generator, used to aim lookups at real rules
  logic [63:0] plan_key  [RULE_COUNT];
  logic [63:0] plan_mask [RULE_COUNT];
  logic        plan_used [RULE_COUNT];

  op_t  op_q[$];
  res_t match_res_q[$];
  op_t  cur_op;

  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_fail = 0;
  int unsigned n_inst_ok = 0;
  int unsigned n_inst_bad = 0;
  int unsigned n_hits = 0;
  int unsigned n_miss = 0;

  // Priority match: lowest claimed slot whose cared bits agree with the word.
  function automatic res_t apply_op(op_t op);
    res_t r;
    r = '0;
    if (op.cmd == CMD_INSTALL) begin
      if (op.idx < RULE_COUNT && !rule_used[op.idx]) begin
        rule_key[op.idx]  = op.key;
        rule_mask[op.idx] = op.mask;
        rule_used[op.idx] = 1'b1;
        r.install_ok = 1'b1;
        n_inst_ok++;
      end else begin
        n_inst_bad++;
      end
    end else begin
      for (int i = RULE_COUNT - 1; i >= 0; i--) begin
        if (rule_used[i] && ((op.word ^ rule_key[i]) & rule_mask[i]) == 64'd0) begin
          r.hit = 1'b1;
          r.hit_index = HIT_IDX_W'(i);
        end
      end
      if (r.hit) n_hits++;
      else n_miss++;
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_install(logic [7:0] idx, logic [63:0] key, logic [63:0] mask);
    op_t op;
    op.cmd  = CMD_INSTALL;
    op.idx  = idx;
    op.key  = key;
    op.mask = mask;
    op.word = rand64();
    if (idx < RULE_COUNT && !plan_used[idx]) begin
      plan_used[idx] = 1'b1;
      plan_key[idx]  = key;
      plan_mask[idx] = mask;
    end
    op_q.push_back(op);
  endtask

  task automatic add_lookup(logic [63:0] word);
    op_t op;
    op.cmd  = CMD_LOOKUP;
    op.idx  = 8'($urandom_range(0, 255));
    op.key  = rand64();
    op.mask = rand64();
    op.word = word;
    op_q.push_back(op);
  endtask

  // Lookup aimed at a planned rule: cared bits from the key, the rest random,
  // sometimes with one random bit flipped so it may fall through.
  task automatic add_aimed_lookup(int unsigned top);
    int unsigned slot;
    logic [63:0] w;
    slot = $urandom_range(0, top);
    if (!plan_used[slot]) begin
      add_lookup(rand64());
    end else begin
      w = (plan_key[slot] & plan_mask[slot]) | (rand64() & ~plan_mask[slot]);
      if ($urandom_range(0, 9) == 0) w ^= 64'd1 << $urandom_range(0, 63);
      add_lookup(w);
    end
  endtask

  function automatic logic [63:0] pick_mask();
    logic [63:0] m;
    case ($urandom_range(0, 3))
      0: m = rand64();
      1: m = '1;
      2: m = rand64() & rand64() & rand64();
      default: m = 64'hFF << (8 * $urandom_range(0, 7));
    endcase
    if (m == 64'd0) m = 64'd1;
    return m;
  endfunction

  // Sender: bursts with random gaps, one pause for a full drain.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic        drain_hold = 1'b0;
  logic        drain_done = 1'b0;

  always @(posedge clk_i) begin
    logic nxt_valid;
    nxt_valid = s_valid;
    if (rst_ni) begin
      if (s_valid && s_axis_tready) begin
        match_res_q.push_back(apply_op(cur_op));
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (gap_left > 0) gap_left--;
      if (drain_hold && match_res_q.size() == 0) drain_hold = 1'b0;
      if (n_accepted == DRAIN_AT && !drain_done) begin
        drain_hold = 1'b1;
        drain_done = 1'b1;
      end
      if (!nxt_valid && gap_left == 0 && !drain_hold && op_q.size() > 0) begin
        cur_op = op_q.pop_front();
        s_tdata <= {cur_op.word, cur_op.mask, cur_op.key, cur_op.idx};
        s_tuser <= cur_op.cmd;
        nxt_valid = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    s_valid <= nxt_valid;
  end

  // Receiver: stall pattern changes mode now and then, plus one long hold-off.
  int unsigned rx_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_results >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_ready <= 1'b1;
          1: m_ready <= 1'($urandom_range(0, 1));
          default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result check against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      got = res_t'(m_axis_tdata[RES_W-1:0]);
      n_results++;
      if (match_res_q.size() == 0) begin
        n_fail++;
        $error("result transfer with nothing outstanding: tdata=%h", m_axis_tdata);
      end else begin
        want = match_res_q.pop_front();
        if (got.install_ok !== want.install_ok) begin
          n_fail++;
          $error("install_ok: expected %0d, got %0d", want.install_ok, got.install_ok);
        end
        if (got.hit !== want.hit) begin
          n_fail++;
          $error("hit: expected %0d, got %0d", want.hit, got.hit);
        end
        if (got.hit_index !== want.hit_index) begin
          n_fail++;
          $error("hit_index: expected %0d, got %0d", want.hit_index, got.hit_index);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned r;
    for (int i = 0; i < RULE_COUNT; i++) begin
      rule_used[i] = 1'b0;
      plan_used[i] = 1'b0;
    end

    // directed: empty table, bad slots, duplicate, priority between overlaps
    add_lookup(64'd0);
    add_lookup('1);
    add_install(8'd16, rand64(), '1);
    add_install(8'd255, rand64(), '1);
    add_install(8'd3, 64'h0123_4567_89AB_CDEF, '1);
    add_install(8'd3, 64'h0, '1);
    add_lookup(64'h0123_4567_89AB_CDEF);
    add_lookup(64'h0123_4567_89AB_CDEE);
    add_lookup(64'h8123_4567_89AB_CDEF);
    add_install(8'd0, 64'hA500_0000_0000_0000, 64'hFF00_0000_0000_0000);
    add_install(8'd1, 64'hA000_0000_0000_0000, 64'hF000_0000_0000_0000);
    add_lookup(64'hA5FF_FFFF_FFFF_FFFF);
    add_lookup(64'hA700_0000_0000_0000);
    add_lookup(64'hB500_0000_0000_0000);
    add_install(8'd14, '1, '1);
    add_lookup('1);
    add_lookup(64'h7FFF_FFFF_FFFF_FFFF);
    add_install(8'd0, 64'h0, 64'h0);
    add_lookup(64'hA500_0000_0000_0000);

    // random: slot 15 stays free so misses remain possible until the end
    for (int n = 0; n < RAND_OPS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        add_install(8'($urandom_range(0, 14)), rand64(), pick_mask());
      end else if (r < 30) begin
        add_install(8'($urandom_range(16, 255)), rand64(), pick_mask());
      end else if (r < 72) begin
        add_aimed_lookup(14);
      end else begin
        add_lookup(rand64());
      end
    end

    // empty care mask in the last slot: every word hits from here on
    add_install(8'd15, rand64(), 64'd0);
    add_install(8'd15, rand64(), '1);
    for (int n = 0; n < 20; n++) begin
      if (n % 2 == 0) add_lookup(rand64());
      else add_aimed_lookup(15);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (op_q.size() == 0 && !s_valid && match_res_q.size() == 0);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results.", n_accepted, n_results);
    $display("Installs %0d taken / %0d refused; lookups %0d hits / %0d misses.",
             n_inst_ok, n_inst_bad, n_hits, n_miss);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== ternary_match_priority_table.f =====
+incdir+hdl
hdl/tmpt_pkg.sv
hdl/tmpt_ram.sv
hdl/tmpt_match.sv
hdl/ternary_match_priority_table.sv
hdl/tmpt_checker.sv
test/tb_top.sv
